// ----- design/wgm3_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm3_pkg: shared constants for the 3D waveguide mesh step block
// Grid geometry, fixed-point widths, command codes and port codes used by
// the mesh sequencer and its node memories.
// ----------------------------------------------------------------------------
package wgm3_pkg;

    // Grid geometry. Node index is {x, y, z}, four bits each.
    localparam int DIM_MAX    = 16;
    localparam int COORD_W    = 4;
    localparam int NODE_W     = 3 * COORD_W;
    localparam int SIZE_W     = 5;
    localparam int PORTS      = 6;
    localparam int PORT_W     = 3;

    // Fixed point: waves Q15.16, coefficients Q1.15.
    localparam int WAVE_W     = 32;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = COEF_W - 1;
    localparam int PROD_W     = WAVE_W + COEF_W;
    localparam int SUM_W      = WAVE_W + 3;
    localparam int MAG_W      = 36;
    localparam int KC_W       = COEF_W + 1;

    // Command codes.
    localparam logic [2:0] OP_SET_KIND  = 3'd0;
    localparam logic [2:0] OP_WRITE_IN  = 3'd1;
    localparam logic [2:0] OP_RUN_STEP  = 3'd2;
    localparam logic [2:0] OP_READ_PRES = 3'd3;
    localparam logic [2:0] OP_READ_OUT  = 3'd4;

    // Wave directions.
    localparam logic [2:0] PORT_UP    = 3'd0;
    localparam logic [2:0] PORT_DOWN  = 3'd1;
    localparam logic [2:0] PORT_RIGHT = 3'd2;
    localparam logic [2:0] PORT_LEFT  = 3'd3;
    localparam logic [2:0] PORT_FRONT = 3'd4;
    localparam logic [2:0] PORT_BACK  = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;

    // Six bits of long division by three, most significant bit first.
    // Returns {remainder, quotient bits}.
    function automatic logic [7:0] div3_step(input logic [1:0] rem, input logic [5:0] bits);
        logic [1:0] r;
        logic [2:0] t;
        logic [5:0] q;
        r = rem;
        q = '0;
        for (int i = 5; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= 3'd3)
            begin
                q[i] = 1'b1;
                t    = t - 3'd3;
            end
            r = t[1:0];
        end
        return {r, q};
    endfunction

    // Effective size: zero acts as one, above the grid acts as the grid.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0)
            return SIZE_W'(1);
        else if (s > SIZE_W'(DIM_MAX))
            return SIZE_W'(DIM_MAX);
        else
            return s;
    endfunction

    // Saturate a 33-bit signed value into a wave word.
    function automatic logic [WAVE_W-1:0] sat33(input logic [WAVE_W:0] v);
        if (v[WAVE_W] != v[WAVE_W-1])
            return v[WAVE_W] ? {1'b1, {(WAVE_W-1){1'b0}}} : {1'b0, {(WAVE_W-1){1'b1}}};
        else
            return v[WAVE_W-1:0];
    endfunction

endpackage

// ----- design/wgm3_ram.sv -----
// ----------------------------------------------------------------------------
// wgm3_ram: simple dual-port node memory
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module wgm3_ram #(
    parameter int W  = 32,
    parameter int AW = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/waveguide_mesh_3d_step.sv -----
// ----------------------------------------------------------------------------
// waveguide_mesh_3d_step: rectilinear 3D waveguide mesh, one step per command
// Holds a 16x16x16 grid of nodes in on-chip memories and runs scatter and
// propagate passes under a small sequencer with one shared arithmetic unit.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake              | Word
//   --------+------------------------+---------------------------------------
//   cmd     | cmd_valid / cmd_ready  | opcode, coords, port, wave, kind, coef
//   rsp     | rsp_valid / rsp_ready  | read_value, done_opcode
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data (sizes x, y, z)
//
// After reset a clearing pass writes zero to every node, one node a cycle;
// cmd_ready stays low meanwhile, configuration is taken.
// Load commands answer straight from idle; reads pass a registered memory read.
// A run step's scatter pass sums, divides by three and saturates at an open
// node; the shared unit then visits the six ports one a cycle, subtracting
// at open nodes and multiplying by the coefficient at reflective ones.
// The propagate pass per node is one node memory read and one write.
// One command is in flight at a time; a waiting response word holds
// cmd_ready low until rsp_ready takes it.
// ----------------------------------------------------------------------------
module waveguide_mesh_3d_step (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [2:0]                    opcode,
    input  logic [wgm3_pkg::COORD_W-1:0]  coord_x,
    input  logic [wgm3_pkg::COORD_W-1:0]  coord_y,
    input  logic [wgm3_pkg::COORD_W-1:0]  coord_z,
    input  logic [wgm3_pkg::PORT_W-1:0]   port,
    input  logic signed [wgm3_pkg::WAVE_W-1:0] wave_value,
    input  logic                          is_reflective,
    input  logic signed [wgm3_pkg::COEF_W-1:0] reflect_coef,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic signed [wgm3_pkg::WAVE_W-1:0] read_value,
    output logic [2:0]                    done_opcode,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [wgm3_pkg::SIZE_W-1:0]   cfg_data
);

    localparam int NW = wgm3_pkg::NODE_W;
    localparam int WW = wgm3_pkg::WAVE_W;
    localparam int CW = wgm3_pkg::COORD_W;

    // Sequencer states.
    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_CMD_RD  = 4'd2;
    localparam logic [3:0] ST_SC_RD   = 4'd3;
    localparam logic [3:0] ST_SC_SUM1 = 4'd4;
    localparam logic [3:0] ST_SC_SUM2 = 4'd5;
    localparam logic [3:0] ST_SC_ABS  = 4'd6;
    localparam logic [3:0] ST_SC_DIV  = 4'd7;
    localparam logic [3:0] ST_SC_SAT  = 4'd8;
    localparam logic [3:0] ST_SC_OUT  = 4'd9;
    localparam logic [3:0] ST_PR_RD   = 4'd10;
    localparam logic [3:0] ST_PR_WR   = 4'd11;

    // Control and datapath registers.
    logic [3:0]                       state_reg, state_next;
    logic [NW-1:0]                    clr_reg, clr_next;
    logic [CW-1:0]                    x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [2:0]                       k_reg, k_next;
    logic signed [wgm3_pkg::SUM_W-1:0] acc_reg, acc_next;
    logic [wgm3_pkg::MAG_W-1:0]       mag_reg, mag_next;
    logic [1:0]                       rem_reg, rem_next;
    logic                             neg_reg, neg_next;
    logic [WW-1:0]                    p_reg, p_next;
    logic signed [wgm3_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [2:0]                       op_reg, op_next;
    logic [2:0]                       port_reg, port_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    logic [WW-1:0]                    read_value_reg, read_value_next;
    logic [2:0]                       done_opcode_reg, done_opcode_next;
    logic [wgm3_pkg::SIZE_W-1:0]      size_x_reg, size_y_reg, size_z_reg;

    // Memory ports.
    logic [wgm3_pkg::PORTS-1:0]       win_we;
    logic [NW-1:0]                    win_waddr [wgm3_pkg::PORTS];
    logic [WW-1:0]                    win_wdata [wgm3_pkg::PORTS];
    logic [WW-1:0]                    win_rdata [wgm3_pkg::PORTS];
    logic [wgm3_pkg::PORTS-1:0]       wout_we;
    logic [NW-1:0]                    wout_waddr;
    logic [WW-1:0]                    wout_wdata;
    logic                             wout_re;
    logic [NW-1:0]                    wout_raddr;
    logic [WW-1:0]                    wout_rdata [wgm3_pkg::PORTS];
    logic                             pres_we, pres_re;
    logic [NW-1:0]                    pres_waddr;
    logic [WW-1:0]                    pres_wdata, pres_rdata;
    logic                             kc_we;
    logic [NW-1:0]                    kc_waddr;
    logic [wgm3_pkg::KC_W-1:0]        kc_wdata, kc_rdata;

    // Helpers.
    logic                             cmd_acc;
    logic [NW-1:0]                    cmd_node, node;
    logic [wgm3_pkg::SIZE_W-1:0]      sx, sy, sz;
    logic                             last_x, last_y, last_z, all_last;
    logic [CW-1:0]                    adv_x, adv_y, adv_z;
    logic [WW-1:0]                    win_k, wout_sel, fin_value;
    logic [7:0]                       div_res;
    logic signed [wgm3_pkg::PROD_W-1:0] prod_adj;
    logic                             node_refl;
    logic signed [wgm3_pkg::COEF_W-1:0] node_coef;

    assign cmd_acc   = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && !rsp_valid_reg;
    assign cfg_ready = 1'b1;
    assign cmd_node  = {coord_x, coord_y, coord_z};
    assign node      = {x_reg, y_reg, z_reg};
    assign node_refl = kc_rdata[wgm3_pkg::COEF_W];
    assign node_coef = kc_rdata[wgm3_pkg::COEF_W-1:0];

    assign rsp_valid   = rsp_valid_reg;
    assign read_value  = read_value_reg;
    assign done_opcode = done_opcode_reg;

    // Grid walk: z runs fastest, then y, then x.
    assign sx     = wgm3_pkg::eff_size(size_x_reg);
    assign sy     = wgm3_pkg::eff_size(size_y_reg);
    assign sz     = wgm3_pkg::eff_size(size_z_reg);
    assign last_x = ({1'b0, x_reg} == sx - 5'd1);
    assign last_y = ({1'b0, y_reg} == sy - 5'd1);
    assign last_z = ({1'b0, z_reg} == sz - 5'd1);
    assign all_last = last_x && last_y && last_z;

    always_comb
    begin
        adv_x = x_reg;
        adv_y = y_reg;
        adv_z = z_reg + 4'd1;
        if (last_z)
        begin
            adv_z = '0;
            adv_y = y_reg + 4'd1;
            if (last_y)
            begin
                adv_y = '0;
                adv_x = x_reg + 4'd1;
            end
        end
    end

    // Incoming wave of the port under work in the scatter output loop.
    always_comb
    begin
        case (k_reg)
            3'd0:    win_k = win_rdata[0];
            3'd1:    win_k = win_rdata[1];
            3'd2:    win_k = win_rdata[2];
            3'd3:    win_k = win_rdata[3];
            3'd4:    win_k = win_rdata[4];
            3'd5:    win_k = win_rdata[5];
            default: win_k = '0;
        endcase
    end

    // Outgoing wave picked by a read command; bad ports read as zero.
    always_comb
    begin
        case (port_reg)
            3'd0:    wout_sel = wout_rdata[0];
            3'd1:    wout_sel = wout_rdata[1];
            3'd2:    wout_sel = wout_rdata[2];
            3'd3:    wout_sel = wout_rdata[3];
            3'd4:    wout_sel = wout_rdata[4];
            3'd5:    wout_sel = wout_rdata[5];
            default: wout_sel = '0;
        endcase
    end

    // Finish of the shared unit: reflective products are shifted down with
    // truncation toward zero, open differences pass; both then saturate.
    assign prod_adj = prod_reg[wgm3_pkg::PROD_W-1]
                    ? prod_reg + wgm3_pkg::PROD_W'((1 << wgm3_pkg::FRAC_W) - 1)
                    : prod_reg;
    assign fin_value = node_refl
                     ? wgm3_pkg::sat33(prod_adj[wgm3_pkg::PROD_W-1:wgm3_pkg::FRAC_W])
                     : wgm3_pkg::sat33(prod_reg[WW:0]);

    assign div_res = wgm3_pkg::div3_step(rem_reg, mag_reg[wgm3_pkg::MAG_W-1 -: 6]);

    // Main sequencer.
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        k_next           = k_reg;
        acc_next         = acc_reg;
        mag_next         = mag_reg;
        rem_next         = rem_reg;
        neg_next         = neg_reg;
        p_next           = p_reg;
        prod_next        = prod_reg;
        op_next          = op_reg;
        port_next        = port_reg;
        rsp_valid_next   = rsp_valid_reg;
        read_value_next  = read_value_reg;
        done_opcode_next = done_opcode_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {NW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    op_next   = opcode;
                    port_next = port;
                    case (opcode)
                        wgm3_pkg::OP_RUN_STEP:
                        begin
                            x_next     = '0;
                            y_next     = '0;
                            z_next     = '0;
                            state_next = ST_SC_RD;
                        end
                        wgm3_pkg::OP_READ_PRES, wgm3_pkg::OP_READ_OUT:
                        begin
                            state_next = ST_CMD_RD;
                        end
                        default:
                        begin
                            rsp_valid_next   = 1'b1;
                            read_value_next  = '0;
                            done_opcode_next = opcode;
                        end
                    endcase
                end
            end
            ST_CMD_RD:
            begin
                rsp_valid_next   = 1'b1;
                done_opcode_next = op_reg;
                read_value_next  = (op_reg == wgm3_pkg::OP_READ_PRES) ? pres_rdata : wout_sel;
                state_next       = ST_IDLE;
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_SUM1;
            end
            ST_SC_SUM1:
            begin
                k_next = '0;
                if (node_refl)
                begin
                    state_next = ST_SC_OUT;
                end
                else
                begin
                    acc_next = wgm3_pkg::SUM_W'(signed'(win_rdata[0]))
                             + wgm3_pkg::SUM_W'(signed'(win_rdata[1]))
                             + wgm3_pkg::SUM_W'(signed'(win_rdata[2]));
                    state_next = ST_SC_SUM2;
                end
            end
            ST_SC_SUM2:
            begin
                acc_next = acc_reg
                         + wgm3_pkg::SUM_W'(signed'(win_rdata[3]))
                         + wgm3_pkg::SUM_W'(signed'(win_rdata[4]))
                         + wgm3_pkg::SUM_W'(signed'(win_rdata[5]));
                state_next = ST_SC_ABS;
            end
            ST_SC_ABS:
            begin
                neg_next   = acc_reg[wgm3_pkg::SUM_W-1];
                mag_next   = wgm3_pkg::MAG_W'(unsigned'(acc_reg[wgm3_pkg::SUM_W-1]
                                                        ? -acc_reg : acc_reg));
                rem_next   = '0;
                k_next     = '0;
                state_next = ST_SC_DIV;
            end
            ST_SC_DIV:
            begin
                // Six quotient bits a cycle shift in from the bottom.
                rem_next = div_res[7:6];
                mag_next = {mag_reg[wgm3_pkg::MAG_W-7:0], div_res[5:0]};
                k_next   = k_reg + 3'd1;
                if (k_reg == 3'd5)
                begin
                    state_next = ST_SC_SAT;
                end
            end
            ST_SC_SAT:
            begin
                if (!neg_reg)
                begin
                    p_next = (mag_reg > wgm3_pkg::MAG_W'({1'b0, {(WW-1){1'b1}}}))
                           ? {1'b0, {(WW-1){1'b1}}} : mag_reg[WW-1:0];
                end
                else
                begin
                    p_next = (mag_reg > wgm3_pkg::MAG_W'({1'b1, {(WW-1){1'b0}}}))
                           ? {1'b1, {(WW-1){1'b0}}} : -mag_reg[WW-1:0];
                end
                k_next     = '0;
                state_next = ST_SC_OUT;
            end
            ST_SC_OUT:
            begin
                // Port k enters the shared unit while port k-1 is written.
                if (k_reg < 3'd6)
                begin
                    if (node_refl)
                    begin
                        prod_next = wgm3_pkg::PROD_W'(node_coef) * wgm3_pkg::PROD_W'(signed'(win_k));
                    end
                    else
                    begin
                        prod_next = wgm3_pkg::PROD_W'(signed'({p_reg[WW-1], p_reg}
                                                             - {win_k[WW-1], win_k}));
                    end
                    k_next = k_reg + 3'd1;
                end
                else
                begin
                    x_next = adv_x;
                    y_next = adv_y;
                    z_next = adv_z;
                    if (all_last)
                    begin
                        x_next     = '0;
                        y_next     = '0;
                        z_next     = '0;
                        state_next = ST_PR_RD;
                    end
                    else
                    begin
                        state_next = ST_SC_RD;
                    end
                end
            end
            ST_PR_RD:
            begin
                state_next = ST_PR_WR;
            end
            ST_PR_WR:
            begin
                x_next = adv_x;
                y_next = adv_y;
                z_next = adv_z;
                if (all_last)
                begin
                    rsp_valid_next   = 1'b1;
                    read_value_next  = '0;
                    done_opcode_next = op_reg;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PR_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Incoming wave memories: cleared, loaded by command, or fed by the
    // neighbor's outgoing wave during the propagate pass.
    always_comb
    begin
        for (int k = 0; k < wgm3_pkg::PORTS; k++)
        begin
            win_we[k]    = 1'b0;
            win_waddr[k] = node;
            win_wdata[k] = '0;
            if (state_reg == ST_CLEAR)
            begin
                win_we[k]    = 1'b1;
                win_waddr[k] = clr_reg;
            end
            else if (state_reg == ST_IDLE)
            begin
                win_we[k]    = cmd_acc && (opcode == wgm3_pkg::OP_WRITE_IN)
                            && (port == 3'(k));
                win_waddr[k] = cmd_node;
                win_wdata[k] = wave_value;
            end
            else if (state_reg == ST_PR_WR)
            begin
                case (3'(k))
                    wgm3_pkg::PORT_FRONT:
                    begin
                        win_we[k]    = (x_reg != '0);
                        win_waddr[k] = {x_reg - 4'd1, y_reg, z_reg};
                        win_wdata[k] = wout_rdata[wgm3_pkg::PORT_BACK];
                    end
                    wgm3_pkg::PORT_BACK:
                    begin
                        win_we[k]    = !last_x;
                        win_waddr[k] = {x_reg + 4'd1, y_reg, z_reg};
                        win_wdata[k] = wout_rdata[wgm3_pkg::PORT_FRONT];
                    end
                    wgm3_pkg::PORT_RIGHT:
                    begin
                        win_we[k]    = (y_reg != '0);
                        win_waddr[k] = {x_reg, y_reg - 4'd1, z_reg};
                        win_wdata[k] = wout_rdata[wgm3_pkg::PORT_LEFT];
                    end
                    wgm3_pkg::PORT_LEFT:
                    begin
                        win_we[k]    = !last_y;
                        win_waddr[k] = {x_reg, y_reg + 4'd1, z_reg};
                        win_wdata[k] = wout_rdata[wgm3_pkg::PORT_RIGHT];
                    end
                    wgm3_pkg::PORT_UP:
                    begin
                        win_we[k]    = (z_reg != '0);
                        win_waddr[k] = {x_reg, y_reg, z_reg - 4'd1};
                        win_wdata[k] = wout_rdata[wgm3_pkg::PORT_DOWN];
                    end
                    wgm3_pkg::PORT_DOWN:
                    begin
                        win_we[k]    = !last_z;
                        win_waddr[k] = {x_reg, y_reg, z_reg + 4'd1};
                        win_wdata[k] = wout_rdata[wgm3_pkg::PORT_UP];
                    end
                    default:
                    begin
                        win_we[k] = 1'b0;
                    end
                endcase
            end
        end
    end

    // Outgoing wave memories: cleared, then written one port a cycle by the scatter pass.
    always_comb
    begin
        for (int k = 0; k < wgm3_pkg::PORTS; k++)
        begin
            wout_we[k] = (state_reg == ST_CLEAR)
                      || ((state_reg == ST_SC_OUT) && (k_reg == 3'(k + 1)));
        end
    end
    assign wout_waddr = (state_reg == ST_CLEAR) ? clr_reg : node;
    assign wout_wdata = (state_reg == ST_CLEAR) ? '0 : fin_value;
    assign wout_re    = (state_reg == ST_PR_RD)
                     || (cmd_acc && (opcode == wgm3_pkg::OP_READ_OUT));
    assign wout_raddr = (state_reg == ST_IDLE) ? cmd_node : node;

    // Pressure memory.
    assign pres_we    = (state_reg == ST_CLEAR) || (state_reg == ST_SC_SAT);
    assign pres_waddr = (state_reg == ST_CLEAR) ? clr_reg : node;
    assign pres_wdata = (state_reg == ST_CLEAR) ? '0 : p_next;
    assign pres_re    = cmd_acc && (opcode == wgm3_pkg::OP_READ_PRES);

    // Node kind and coefficient memory.
    assign kc_we    = (state_reg == ST_CLEAR)
                   || (cmd_acc && (opcode == wgm3_pkg::OP_SET_KIND));
    assign kc_waddr = (state_reg == ST_CLEAR) ? clr_reg : cmd_node;
    assign kc_wdata = (state_reg == ST_CLEAR) ? '0 : {is_reflective, reflect_coef};

    for (genvar g = 0; g < wgm3_pkg::PORTS; g++)
    begin : g_port
        wgm3_ram #(.W(WW), .AW(NW)) u_win (
            .clk   (clk),
            .we    (win_we[g]),
            .waddr (win_waddr[g]),
            .wdata (win_wdata[g]),
            .re    (state_reg == ST_SC_RD),
            .raddr (node),
            .rdata (win_rdata[g])
        );
        wgm3_ram #(.W(WW), .AW(NW)) u_wout (
            .clk   (clk),
            .we    (wout_we[g]),
            .waddr (wout_waddr),
            .wdata (wout_wdata),
            .re    (wout_re),
            .raddr (wout_raddr),
            .rdata (wout_rdata[g])
        );
    end

    wgm3_ram #(.W(WW), .AW(NW)) u_pres (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .re    (pres_re),
        .raddr (cmd_node),
        .rdata (pres_rdata)
    );

    wgm3_ram #(.W(wgm3_pkg::KC_W), .AW(NW)) u_kc (
        .clk   (clk),
        .we    (kc_we),
        .waddr (kc_waddr),
        .wdata (kc_wdata),
        .re    (state_reg == ST_SC_RD),
        .raddr (node),
        .rdata (kc_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            size_x_reg    <= wgm3_pkg::SIZE_W'(wgm3_pkg::DIM_MAX);
            size_y_reg    <= wgm3_pkg::SIZE_W'(wgm3_pkg::DIM_MAX);
            size_z_reg    <= wgm3_pkg::SIZE_W'(wgm3_pkg::DIM_MAX);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            z_reg         <= z_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    wgm3_pkg::CFG_SIZE_X: size_x_reg <= cfg_data;
                    wgm3_pkg::CFG_SIZE_Y: size_y_reg <= cfg_data;
                    wgm3_pkg::CFG_SIZE_Z: size_z_reg <= cfg_data;
                    default:              size_x_reg <= size_x_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg         <= acc_next;
        mag_reg         <= mag_next;
        rem_reg         <= rem_next;
        neg_reg         <= neg_next;
        p_reg           <= p_next;
        prod_reg        <= prod_next;
        op_reg          <= op_next;
        port_reg        <= port_next;
        read_value_reg  <= read_value_next;
        done_opcode_reg <= done_opcode_next;
    end

`ifndef ASSERT_OFF
    // No response word may appear while the memories are being cleared.
    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !rsp_valid_reg)
        else $error("response during clearing pass");

    // A taken command closes the command channel on the next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> !cmd_ready)
        else $error("second command taken while one is in flight");

    // The grid walk stays inside the used region.
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_OUT || state_reg == ST_PR_WR)
        |-> ({1'b0, x_reg} < sx) && ({1'b0, y_reg} < sy) && ({1'b0, z_reg} < sz))
        else $error("node walk left the used grid");

    // The output loop never runs past the last port.
    a_port_loop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_OUT) |-> (k_reg <= 3'd6))
        else $error("scatter port counter overran");
`endif

endmodule
